FILE: rtl/core/gis_pkg.sv
// Shared widths and the front-to-back queue entry for the gcd interleave stream.
package gis_pkg;

    localparam int VALUE_BITS = 31;
    localparam int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int K_BITS     = $clog2(VALUE_BITS);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [VALUE_BITS-1:0] prev;
        logic                  need_gcd;
    } t_entry;

endpackage

FILE: rtl/core/gcd_interleave_stream_top.sv
// Top level of the gcd interleave stream: front end, queue and gcd back end.
//
//  channel  dir  tdata (low bit up)        tuser    tlast
//  s_*      in   value[30:0], pad 0        first    -
//  m_*      out  result_value[30:0], pad 0 is_gcd   last
//
// A word that starts a sequence goes from the queue straight to the output; a word that
// needs a gcd is loaded, takes one binary gcd step per cycle until an operand is zero,
// and then sends the gcd word and the value word, each waiting while the output stalls.
// Reset is synchronous, active low, and clears the previous-element flag and the queue.
// The two-entry queue lets input words land while the back end works or output stalls.
module gcd_interleave_stream_top
    import gis_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [DATA_BITS-1:0] i_s_tdata,   // value, zero pad
    input  logic                 i_s_tuser,   // first
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [DATA_BITS-1:0] o_m_tdata,   // result_value, zero pad
    output logic                 o_m_tuser,   // is_gcd
    output logic                 o_m_tlast
);

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    t_entry push_entry;
    t_entry head_entry;

    gis_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    gis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (head_entry)
    );

    gis_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_entry    (head_entry),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: rtl/core/gis_front.sv
// Front end: accepts input words, tracks the previous element and classifies each word.
module gis_front
    import gis_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [DATA_BITS-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_entry               o_entry
);

    logic [VALUE_BITS-1:0] r_prev;
    logic                  r_have_prev;
    logic                  accept;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && !i_q_full;
    assign o_push     = accept;

    always_comb begin
        o_entry.value    = i_s_tdata[VALUE_BITS-1:0];
        o_entry.prev     = r_prev;
        // a gcd goes in only inside a running sequence
        o_entry.need_gcd = !i_s_tuser && r_have_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else if (accept) begin
            r_prev      <= i_s_tdata[VALUE_BITS-1:0];
            r_have_prev <= 1'b1;
        end
    end

endmodule

FILE: rtl/core/gis_queue.sv
// Two-entry queue between front end and gcd back end.
module gis_queue
    import gis_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_entry
);

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/gis_back.sv
// Back end: binary gcd engine, one step per cycle, and the registered output word.
module gis_back
    import gis_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  t_entry               i_entry,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [DATA_BITS-1:0] o_m_tdata,
    output logic                 o_m_tuser,
    output logic                 o_m_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_SEND_GCD,
        S_SEND_VAL
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_a;
    logic [VALUE_BITS-1:0] r_b;
    logic [K_BITS-1:0]     r_k;
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] r_res;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_gcd;
    logic                  r_out_last;

    logic                  slot_free;
    logic                  out_load;
    logic                  calc_done;
    logic [VALUE_BITS-1:0] n_a;
    logic [VALUE_BITS-1:0] n_b;
    logic [K_BITS-1:0]     n_k;
    logic [VALUE_BITS-1:0] n_res;

    assign slot_free = !r_out_valid || i_m_tready;
    assign out_load  = slot_free && ((r_state == S_SEND_GCD) || (r_state == S_SEND_VAL));
    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DATA_BITS'(r_out_value);
    assign o_m_tuser  = r_out_gcd;
    assign o_m_tlast  = r_out_last;

    // Stein step: strip common twos into k, then halve or subtract-and-halve
    always_comb begin
        calc_done = (r_a == '0) || (r_b == '0);
        n_res     = VALUE_BITS'((r_a | r_b) << r_k);
        n_a       = r_a;
        n_b       = r_b;
        n_k       = r_k;
        if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + K_BITS'(1);
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (r_a >= r_b) begin
            n_a = (r_a - r_b) >> 1;
        end else begin
            n_b = (r_b - r_a) >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_a     <= i_entry.prev;
                        r_b     <= i_entry.value;
                        r_k     <= '0;
                        r_value <= i_entry.value;
                        r_state <= i_entry.need_gcd ? S_CALC : S_SEND_VAL;
                    end
                end
                S_CALC: begin
                    if (calc_done) begin
                        r_res   <= n_res;
                        r_state <= S_SEND_GCD;
                    end else begin
                        r_a <= n_a;
                        r_b <= n_b;
                        r_k <= n_k;
                    end
                end
                S_SEND_GCD: begin
                    if (slot_free) begin
                        r_out_value <= r_res;
                        r_out_gcd   <= 1'b1;
                        r_out_last  <= 1'b0;
                        r_state     <= S_SEND_VAL;
                    end
                end
                S_SEND_VAL: begin
                    if (slot_free) begin
                        r_out_value <= r_value;
                        r_out_gcd   <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: verif/gcd_interleave_stream_checker.sv
// Checker for the gcd interleave stream: predicts the output words and compares them.
`timescale 1ns / 1ps

module gcd_interleave_stream_checker
    import gis_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [DATA_BITS-1:0] i_s_tdata,   // value, zero pad
    input  logic                 i_s_tuser,   // first
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [DATA_BITS-1:0] i_m_tdata,   // result_value, zero pad
    input  logic                 i_m_tuser,   // is_gcd
    input  logic                 i_m_tlast,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  is_gcd;
        logic                  last;
    } t_out_word;

    t_out_word             pending_words[$];
    logic [VALUE_BITS-1:0] prev_value;
    logic                  have_prev;

    function automatic logic [VALUE_BITS-1:0] euclid(input logic [VALUE_BITS-1:0] a,
                                                     input logic [VALUE_BITS-1:0] b);
        logic [VALUE_BITS-1:0] x;
        logic [VALUE_BITS-1:0] y;
        logic [VALUE_BITS-1:0] r;
        x = a;
        y = b;
        while (y != '0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word             want;
        logic [VALUE_BITS-1:0] in_value;
        if (!i_rst_n) begin
            pending_words.delete();
            prev_value = '0;
            have_prev  = 1'b0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected output word: result_value %0d is_gcd %0b last %0b",
                           i_m_tdata[VALUE_BITS-1:0], i_m_tuser, i_m_tlast);
                    o_mismatches++;
                end else begin
                    want = pending_words.pop_front();
                    if (i_m_tdata[VALUE_BITS-1:0] !== want.value) begin
                        $error("result_value: expected %0d, got %0d",
                               want.value, i_m_tdata[VALUE_BITS-1:0]);
                        o_mismatches++;
                    end
                    if (i_m_tdata[DATA_BITS-1:VALUE_BITS] !== '0) begin
                        $error("tdata pad: expected 0, got %0h",
                               i_m_tdata[DATA_BITS-1:VALUE_BITS]);
                        o_mismatches++;
                    end
                    if (i_m_tuser !== want.is_gcd) begin
                        $error("is_gcd: expected %0b, got %0b", want.is_gcd, i_m_tuser);
                        o_mismatches++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_m_tlast);
                        o_mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                in_value = i_s_tdata[VALUE_BITS-1:0];
                // no previous element acts like a sequence start
                if (i_s_tuser || !have_prev) begin
                    pending_words.push_back('{value: in_value, is_gcd: 1'b0, last: 1'b1});
                end else begin
                    pending_words.push_back('{value: euclid(prev_value, in_value),
                                              is_gcd: 1'b1, last: 1'b0});
                    pending_words.push_back('{value: in_value, is_gcd: 1'b0, last: 1'b1});
                end
                prev_value = in_value;
                have_prev  = 1'b1;
            end
        end
        o_outstanding = pending_words.size();
    end

endmodule

FILE: verif/gcd_interleave_stream_top_tb.sv
// Testbench top for the gcd interleave stream: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module gcd_interleave_stream_top_tb;
    import gis_pkg::*;

    localparam int                    RANDOM_WORDS = 850;
    localparam int                    QUIET_WORDS  = 60;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX    = '1;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [DATA_BITS-1:0] i_s_tdata  = '0;   // value, zero pad
    logic                 i_s_tuser  = 1'b0; // first
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [DATA_BITS-1:0] o_m_tdata;         // result_value, zero pad
    logic                 o_m_tuser;         // is_gcd
    logic                 o_m_tlast;

    int mismatches;
    int outstanding;
    bit quiet = 1'b0;
    int words_sent = 0;

    gcd_interleave_stream_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    gcd_interleave_stream_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_m_tlast     (o_m_tlast),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offer one word and hold it until accepted; returns at a falling edge
    task automatic send_word(input logic [VALUE_BITS-1:0] value, input logic first);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= DATA_BITS'(value);
        i_s_tuser  <= first;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // mix of zero, max, tiny values, multiples of a shared factor and full random
    function automatic logic [VALUE_BITS-1:0] pick_value(input int unsigned factor);
        int unsigned k;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return VALUE_MAX;
            2, 3: return VALUE_BITS'($urandom_range(0, 31));
            4, 5, 6: begin
                k = $urandom_range(1, int'(VALUE_MAX) / factor);
                return VALUE_BITS'(factor * k);
            end
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned factor;
        int          seq_len;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // nothing seen yet: passes through even without first
        send_word(31'd12, 1'b0);
        send_word(31'd18, 1'b0);
        send_word(31'd0, 1'b0);
        send_word(31'd0, 1'b0);
        send_word(31'd7, 1'b0);
        // first flag ends the old sequence, no gcd
        send_word(VALUE_MAX, 1'b1);
        send_word(VALUE_MAX, 1'b0);
        send_word(VALUE_MAX - VALUE_BITS'(1), 1'b0);
        send_word(31'd1, 1'b0);
        send_word(31'h4000_0000, 1'b0);
        send_word(31'h4000_0000, 1'b0);
        send_word(31'h6000_0000, 1'b0);
        // consecutive Fibonacci numbers: longest Euclid chain
        send_word(31'd1134903170, 1'b1);
        send_word(31'd1836311903, 1'b0);
        send_word(31'd0, 1'b1);
        send_word(31'd0, 1'b0);
        send_word(31'h5555_5555, 1'b0);
        send_word(31'h2AAA_AAAA, 1'b0);
        send_word(31'd1, 1'b1);
        send_word(31'd0, 1'b0);
        send_word(VALUE_BITS'(123456789 * 3), 1'b1);
        send_word(VALUE_BITS'(123456789 * 5), 1'b0);

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            factor = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 65535);
            if ($urandom_range(0, 9) == 0) begin
                // noise: random first flag, no sequence structure
                send_word(pick_value(factor), 1'($urandom_range(0, 1)));
            end else begin
                seq_len = $urandom_range(1, 8);
                send_word(pick_value(factor), 1'b1);
                repeat (seq_len - 1) send_word(pick_value(factor), 1'b0);
            end
            if (words_sent >= RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
        end

        i_s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("gcd_interleave_stream_top verification clean");
        end else begin
            $display("gcd_interleave_stream_top verification failed");
        end
        $finish;
    end

    // output flow control; one long hold-off fills the queue and backs up the input
    initial begin : receiver
        int cycles;
        int n;
        bit held;
        cycles = 0;
        held   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && cycles >= 2500) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                n = 400;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                n = $urandom_range(1, 6);
            end else begin
                i_m_tready <= 1'b1;
                n = quiet ? 1 : $urandom_range(1, 16);
            end
            repeat (n) @(negedge i_clk);
            cycles += n;
        end
    end

    initial begin : watchdog
        #6_000_000;
        $display("gcd_interleave_stream_top verification failed");
        $finish;
    end

endmodule
